>>> hdl/pts_pkg.sv
`default_nettype none

package pts_pkg;

    localparam int unsigned CodeW    = 16;
    localparam int unsigned TicksW   = 16;
    localparam int unsigned CountW   = 8;
    localparam int unsigned ElapsedW = 32;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned CfgIdxW  = 3;

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        REG_PULSE_TICKS      = 3'd0,
        REG_GAP_TICKS        = 3'd1,
        REG_PULSES_PER_TRAIN = 3'd2,
        REG_REFRACTORY_TICKS = 3'd3,
        REG_AMPLITUDE_CODE   = 3'd4,
        REG_BASELINE_CODE    = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [TicksW-1:0]   pulse_ticks;
        logic [TicksW-1:0]   gap_ticks;
        logic [CountW-1:0]   pulses_per_train;
        logic [ElapsedW-1:0] refractory_ticks;
        logic [CodeW-1:0]    amplitude_code;
        logic [CodeW-1:0]    baseline_code;
    } t_cfg;

    typedef struct packed {
        logic [CodeW-1:0] drive_code;
        logic             pulse_high;
        logic             train_active;
        logic             train_start;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/pts_if.sv
`default_nettype none

interface pts_in_if;
    logic valid;
    logic ready;
    logic stim_request;
    logic run_enable;

    modport source (output valid, output stim_request, output run_enable, input ready);
    modport sink   (input valid, input stim_request, input run_enable, output ready);
endinterface

interface pts_out_if;
    logic                       valid;
    logic                       ready;
    logic [pts_pkg::CodeW-1:0]  drive_code;
    logic                       pulse_high;
    logic                       train_active;
    logic                       train_start;

    modport source (output valid, output drive_code, output pulse_high,
                    output train_active, output train_start, input ready);
    modport sink   (input valid, input drive_code, input pulse_high,
                    input train_active, input train_start, output ready);
endinterface

`default_nettype wire

>>> hdl/pts_train.sv
`default_nettype none

module pts_train (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic            i_stim_request,
    input  wire logic            i_run_enable,
    input  wire pts_pkg::t_cfg   i_cfg,
    output pts_pkg::t_result     o_result
);
    import pts_pkg::*;

    localparam logic [ElapsedW-1:0] ElapsedMax = '1;

    logic [ElapsedW-1:0] r_elapsed, n_elapsed;
    logic [TicksW-1:0]   r_phase,   n_phase;
    logic [CountW-1:0]   r_index,   n_index;
    logic                r_in_train, n_in_train;
    logic                r_level,   n_level;
    logic                r_was_en;

    logic                en_rise;
    logic                start;
    logic [ElapsedW-1:0] elapsed_a;
    logic [ElapsedW-1:0] elapsed_b;
    logic [TicksW:0]     phase_next;
    logic [TicksW-1:0]   pulse_lim;
    logic [TicksW-1:0]   gap_lim;
    logic [CountW-1:0]   index_next;
    logic                high;

    always_comb begin
        // a zero length counts as one tick
        pulse_lim = (i_cfg.pulse_ticks == '0) ? TicksW'(1) : i_cfg.pulse_ticks;
        gap_lim   = (i_cfg.gap_ticks == '0) ? TicksW'(1) : i_cfg.gap_ticks;

        en_rise   = i_run_enable && !r_was_en && !r_in_train;
        elapsed_a = en_rise ? '0 : r_elapsed;
        start     = !r_in_train && i_run_enable && i_stim_request
                    && (elapsed_a > i_cfg.refractory_ticks);

        elapsed_b  = start ? '0 : elapsed_a;
        n_phase    = start ? '0 : r_phase;
        n_index    = start ? '0 : r_index;
        n_in_train = start ? (i_cfg.pulses_per_train != '0) : r_in_train;
        n_level    = start ? (i_cfg.pulses_per_train != '0) : r_level;

        high = n_in_train && n_level;
        o_result.drive_code   = high ? i_cfg.amplitude_code : i_cfg.baseline_code;
        o_result.pulse_high   = high;
        o_result.train_active = n_in_train;
        o_result.train_start  = start;

        phase_next = {1'b0, n_phase} + (TicksW+1)'(1);
        index_next = n_index + CountW'(1);
        if (n_in_train) begin
            if (n_level) begin
                if (phase_next >= {1'b0, pulse_lim}) begin
                    n_level = 1'b0;
                    n_phase = '0;
                end else begin
                    n_phase = phase_next[TicksW-1:0];
                end
            end else begin
                if (phase_next >= {1'b0, gap_lim}) begin
                    n_phase = '0;
                    if (index_next >= i_cfg.pulses_per_train) begin
                        n_in_train = 1'b0;
                        n_index    = '0;
                    end else begin
                        n_index = index_next;
                        n_level = 1'b1;
                    end
                end else begin
                    n_phase = phase_next[TicksW-1:0];
                end
            end
        end

        // saturate rather than wrap
        n_elapsed = (elapsed_b == ElapsedMax) ? elapsed_b : elapsed_b + ElapsedW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed  <= '0;
            r_phase    <= '0;
            r_index    <= '0;
            r_in_train <= 1'b0;
            r_level    <= 1'b0;
            r_was_en   <= 1'b0;
        end else if (i_step) begin
            r_elapsed  <= n_elapsed;
            r_phase    <= n_phase;
            r_index    <= n_index;
            r_in_train <= n_in_train;
            r_level    <= n_level;
            r_was_en   <= i_run_enable;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pulse_train_stimulator_core.sv
`default_nettype none

// Pulse train stimulator. Each input beat is one time tick carrying a
// stimulation request and a run enable; each produces exactly one result beat
// with the drive code, the pulse level, the train-active flag and a train-start
// strobe. A request starts a train when the block is enabled, no train is
// running and more than refractory_ticks ticks have passed since the last
// start (or since a rising enable seen outside a train). A train is
// pulses_per_train pulses of amplitude_code for pulse_ticks ticks followed by
// baseline_code for gap_ticks ticks, and always runs to its end. A length of
// zero ticks counts as one; zero pulses per train flags the start but drives
// baseline only. Throughput is one beat per clock: the tick's state update and
// result are computed combinationally from the train state registers, and
// the result lands in the output register when the tick is accepted. The input
// stalls only while that output register holds a beat the sink has not taken.
// Configure through i_cfg_we/i_cfg_idx/i_cfg_wdata only while no beat is in
// flight; indexes beyond the register list are ignored.
module pulse_train_stimulator_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [pts_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [pts_pkg::CfgDataW-1:0] i_cfg_wdata,
    pts_in_if.sink                         i_stim,
    pts_out_if.source                      o_res
);
    import pts_pkg::*;

    t_cfg    r_cfg;
    t_result step_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_accept;

    // Accept a tick whenever the output register is empty or being drained
    assign i_stim.ready = !r_out_valid || o_res.ready;
    assign in_accept    = i_stim.valid && i_stim.ready;

    // Configuration registers, reset to their documented defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks      <= TicksW'(1);
            r_cfg.gap_ticks        <= TicksW'(5);
            r_cfg.pulses_per_train <= CountW'(10);
            r_cfg.refractory_ticks <= ElapsedW'(200);
            r_cfg.amplitude_code   <= '0;
            r_cfg.baseline_code    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PULSE_TICKS:      r_cfg.pulse_ticks      <= i_cfg_wdata[TicksW-1:0];
                REG_GAP_TICKS:        r_cfg.gap_ticks        <= i_cfg_wdata[TicksW-1:0];
                REG_PULSES_PER_TRAIN: r_cfg.pulses_per_train <= i_cfg_wdata[CountW-1:0];
                REG_REFRACTORY_TICKS: r_cfg.refractory_ticks <= i_cfg_wdata[ElapsedW-1:0];
                REG_AMPLITUDE_CODE:   r_cfg.amplitude_code   <= i_cfg_wdata[CodeW-1:0];
                REG_BASELINE_CODE:    r_cfg.baseline_code    <= i_cfg_wdata[CodeW-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Train sequencer: advance state once per accepted tick
    pts_train u_train (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_accept),
        .i_stim_request (i_stim.stim_request),
        .i_run_enable   (i_stim.run_enable),
        .i_cfg          (r_cfg),
        .o_result       (step_res)
    );

    // Output register: hold the beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= step_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.drive_code   = r_res.drive_code;
    assign o_res.pulse_high   = r_res.pulse_high;
    assign o_res.train_active = r_res.train_active;
    assign o_res.train_start  = r_res.train_start;

    // A pulse is only ever driven inside a train
    a_high_in_train: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.pulse_high |-> r_res.train_active)
        else $error("pulse level high outside a train");

    // A train with pulses opens on its first pulse
    a_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.train_start && (r_cfg.pulses_per_train != '0)
        |-> r_res.pulse_high && r_res.drive_code == r_cfg.amplitude_code)
        else $error("train start without first pulse");

    // An empty output register never stalls the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_stim.ready)
        else $error("input stalled with empty output register");

    // Every accepted tick leaves a result beat in the next cycle
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted tick produced no result");

endmodule

`default_nettype wire

>>> dv/pulse_train_stimulator_core_test.sv
`timescale 1ns / 100ps

module pulse_train_stimulator_core_test;

    import pts_pkg::*;

    // Cycles with no beat on either side before the run is declared hung
    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic stim_request;
        logic run_enable;
    } t_tick;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_wdata;

    pts_in_if  stim_if ();
    pts_out_if res_if ();

    pulse_train_stimulator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stim      (stim_if),
        .o_res       (res_if)
    );

    // Ticks waiting to be sent, and the drive beats they are due to produce
    t_tick   ticks_to_send[$];
    t_result drive_due[$];

    // Shadow of the register file and of the train state
    t_cfg        cfg_now;
    logic [31:0] since_start;
    logic [15:0] phase_ticks;
    logic [7:0]  pulses_done;
    logic        train_on;
    logic        at_amplitude;
    logic        enable_seen;

    // Sender burst shaping and receiver stall pattern
    int          burst_left;
    int          gap_left;
    t_tick       next_tick;
    logic [31:0] stall_mask;
    logic [4:0]  stall_step;

    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    t_result seen_beat;
    t_result want_beat;

    // A length of zero ticks still lasts one tick
    function automatic logic [16:0] min_one(input logic [15:0] n);
        return (n == '0) ? 17'd1 : {1'b0, n};
    endfunction

    // Work out the drive beat for one tick and advance the shadow state
    function automatic t_result train_tick(input t_tick tick);
        t_result     beat;
        logic        started;
        logic [16:0] next_phase;
        started = 1'b0;
        // A rising enable restarts timing, but never in the middle of a train
        if (tick.run_enable && !enable_seen && !train_on)
            since_start = '0;
        enable_seen = tick.run_enable;
        if (!train_on && tick.run_enable && tick.stim_request &&
            since_start > cfg_now.refractory_ticks) begin
            started      = 1'b1;
            since_start  = '0;
            phase_ticks  = '0;
            pulses_done  = '0;
            // With no pulses configured the start is flagged but nothing runs
            train_on     = (cfg_now.pulses_per_train != '0);
            at_amplitude = train_on;
        end
        beat.pulse_high   = train_on && at_amplitude;
        beat.drive_code   = beat.pulse_high ? cfg_now.amplitude_code : cfg_now.baseline_code;
        beat.train_active = train_on;
        beat.train_start  = started;
        if (train_on) begin
            next_phase = phase_ticks + 17'd1;
            if (at_amplitude) begin
                if (next_phase >= min_one(cfg_now.pulse_ticks)) begin
                    at_amplitude = 1'b0;
                    phase_ticks  = '0;
                end else begin
                    phase_ticks = next_phase[15:0];
                end
            end else if (next_phase >= min_one(cfg_now.gap_ticks)) begin
                // End of a gap closes one pulse; the last one ends the train
                phase_ticks = '0;
                pulses_done = pulses_done + 8'd1;
                if (pulses_done >= cfg_now.pulses_per_train) begin
                    train_on    = 1'b0;
                    pulses_done = '0;
                end else begin
                    at_amplitude = 1'b1;
                end
            end else begin
                phase_ticks = next_phase[15:0];
            end
        end
        // Saturate rather than wrap
        if (since_start != '1)
            since_start = since_start + 32'd1;
        return beat;
    endfunction

    task automatic flag_beat(input string note, input t_result want, input t_result got);
        if (mismatch_count < 10)
            $display({"%0t %s: want code %h high %b active %b start %b,",
                      " got code %h high %b active %b start %b"},
                     $time, note, want.drive_code, want.pulse_high, want.train_active,
                     want.train_start, got.drive_code, got.pulse_high, got.train_active,
                     got.train_start);
        mismatch_count++;
    endtask

    // Write one register and mirror it; only called with nothing in flight
    task automatic write_reg(input t_cfg_reg idx, input logic [CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PULSE_TICKS:      cfg_now.pulse_ticks      = data[TicksW-1:0];
            REG_GAP_TICKS:        cfg_now.gap_ticks        = data[TicksW-1:0];
            REG_PULSES_PER_TRAIN: cfg_now.pulses_per_train = data[CountW-1:0];
            REG_REFRACTORY_TICKS: cfg_now.refractory_ticks = data[ElapsedW-1:0];
            REG_AMPLITUDE_CODE:   cfg_now.amplitude_code   = data[CodeW-1:0];
            REG_BASELINE_CODE:    cfg_now.baseline_code    = data[CodeW-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] pulse, input logic [31:0] gap,
                             input logic [31:0] count, input logic [31:0] refractory,
                             input logic [31:0] amplitude, input logic [31:0] baseline);
        write_reg(REG_PULSE_TICKS, pulse);
        write_reg(REG_GAP_TICKS, gap);
        write_reg(REG_PULSES_PER_TRAIN, count);
        write_reg(REG_REFRACTORY_TICKS, refractory);
        write_reg(REG_AMPLITUDE_CODE, amplitude);
        write_reg(REG_BASELINE_CODE, baseline);
    endtask

    task automatic queue_tick(input logic request, input logic enable);
        t_tick tick;
        tick.stim_request = request;
        tick.run_enable   = enable;
        ticks_to_send.push_back(tick);
    endtask

    // Hold until every queued tick is sent and every drive beat has come back;
    // look at the falling edge so that the rising edge's updates have settled
    task automatic drain;
        while (ticks_to_send.size() != 0 || stim_if.valid || drive_due.size() != 0)
            @(negedge i_clk);
        // The output is registered; leave a little margin before touching registers
        repeat (2) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: predict each accepted tick, then offer the next one in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stim_if.valid        <= 1'b0;
            stim_if.stim_request <= 1'b0;
            stim_if.run_enable   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            since_start  = '0;
            phase_ticks  = '0;
            pulses_done  = '0;
            train_on     = 1'b0;
            at_amplitude = 1'b0;
            enable_seen  = 1'b0;
        end else begin
            if (stim_if.valid && stim_if.ready) begin
                next_tick.stim_request = stim_if.stim_request;
                next_tick.run_enable   = stim_if.run_enable;
                drive_due.push_back(train_tick(next_tick));
            end
            // Only move on once the current beat has gone or none is offered
            if (!stim_if.valid || stim_if.ready) begin
                if (gap_left != 0 || ticks_to_send.size() == 0) begin
                    if (gap_left != 0)
                        gap_left--;
                    stim_if.valid <= 1'b0;
                end else begin
                    next_tick = ticks_to_send.pop_front();
                    stim_if.valid        <= 1'b1;
                    stim_if.stim_request <= next_tick.stim_request;
                    stim_if.run_enable   <= next_tick.run_enable;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        // New burst; one in four runs straight on with no gap
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Monitor: check each drive beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_step   <= '0;
            stall_mask   <= '1;
        end else begin
            if (res_if.valid && res_if.ready) begin
                seen_beat.drive_code   = res_if.drive_code;
                seen_beat.pulse_high   = res_if.pulse_high;
                seen_beat.train_active = res_if.train_active;
                seen_beat.train_start  = res_if.train_start;
                if (drive_due.size() == 0) begin
                    flag_beat("beat with nothing due", '0, seen_beat);
                end else begin
                    want_beat = drive_due.pop_front();
                    if (seen_beat !== want_beat)
                        flag_beat("drive beat mismatch", want_beat, seen_beat);
                end
            end
            // Step through a 32-bit ready pattern, redrawn each time round
            res_if.ready <= stall_mask[stall_step];
            stall_step   <= stall_step + 5'd1;
            if (stall_step == 5'd31) begin
                case ($urandom_range(0, 3))
                    0:       stall_mask <= '1;
                    1:       stall_mask <= $urandom;
                    2:       stall_mask <= $urandom | $urandom;
                    default: stall_mask <= $urandom & $urandom;
                endcase
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (stim_if.valid && stim_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("pulse_train_stimulator_core_test: errors");
        $finish;
    end

    // Stimulus: directed checks of the corner cases, then random phases
    initial begin
        int          phase;
        int          n_ticks;
        int          density;
        logic        run_on;
        logic [15:0] start_en;
        logic [31:0] pulse;
        logic [31:0] gap;
        logic [31:0] count;
        logic [31:0] refractory;

        // Known levels from time zero, and the register file's reset values
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_PULSE_TICKS;
        i_cfg_wdata = '0;
        cfg_now.pulse_ticks      = 16'd1;
        cfg_now.gap_ticks        = 16'd5;
        cfg_now.pulses_per_train = 8'd10;
        cfg_now.refractory_ticks = 32'd200;
        cfg_now.amplitude_code   = '0;
        cfg_now.baseline_code    = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short train with a low refractory: enable off, rising enable,
        // waiting out the refractory, enable dropped and raised mid-train,
        // and a back to back start right after the last gap tick
        write_all(32'd2, 32'd1, 32'd2, 32'd3, 32'h0000_FFFF, 32'h0000_0000);
        start_en = 16'b1111_1110_0111_1110;
        for (int i = 0; i < 16; i++)
            queue_tick(1'b1, start_en[i]);
        drain();

        // Zero pulses per train and zero lengths; junk above the register widths
        write_all(32'hFFFF_0000, 32'hA5A5_0000, 32'hFFFF_FF00, 32'd0,
                  32'hFFFF_1234, 32'h5A5A_ABCD);
        repeat (2) queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        drain();
        write_reg(REG_PULSES_PER_TRAIN, 32'd1);
        repeat (3) queue_tick(1'b1, 1'b1);
        drain();

        // Extremes: a refractory that is never exceeded, then none at all
        write_all(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_00FF, 32'hFFFF_FFFF,
                  32'h0000_FFFF, 32'h0000_0000);
        repeat (2) queue_tick(1'b1, 1'b1);
        drain();
        write_reg(REG_REFRACTORY_TICKS, 32'd0);
        repeat (2) queue_tick(1'b1, 1'b1);
        drain();

        for (phase = 0; phase < 13; phase++) begin
            // Mostly short trains and refractories so that many trains fire
            case ($urandom_range(0, 9))
                0:       pulse = $urandom;
                1:       pulse = 32'd0;
                default: pulse = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 9))
                0:       gap = $urandom;
                1:       gap = 32'd0;
                default: gap = $urandom_range(1, 4);
            endcase
            count      = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
            refractory = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
            write_all(pulse, gap, count, refractory, $urandom, $urandom);

            n_ticks = $urandom_range(90, 130);
            density = $urandom_range(2, 9);
            run_on  = 1'b1;
            for (int i = 0; i < n_ticks; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any combination of request and enable
                    queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    if ($urandom_range(0, 29) == 0)
                        run_on = !run_on;
                    queue_tick($urandom_range(0, 9) < density, run_on);
                end
                // Midway through one phase, hold the sender until all is back
                if (phase == 5 && i == n_ticks / 2)
                    drain();
            end
            drain();
        end

        // Leave room for any stray beat to show up
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("pulse_train_stimulator_core_test: clean");
        else
            $display("pulse_train_stimulator_core_test: errors");
        $finish;
    end

endmodule
